FILE: design/bru_pkg.sv
// ----------------------------------------------------------------------------
// bru_pkg
// Types and constants shared by the BMP row pixel unpacker modules.
// ----------------------------------------------------------------------------
package bru_pkg;

  // Width of the image dimension registers.
  localparam int DimW = 13;
  // Largest accepted image dimension; larger register values are clamped.
  localparam logic [DimW-1:0] MaxDim = 13'd4096;
  // Width of the byte position counter within a row.
  localparam int RowByteW = 15;
  // Width of the reported column and row fields.
  localparam int CoordW = 12;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] RegDepth  = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [2:0]      DepthReset  = 3'd2;
  localparam logic [DimW-1:0] WidthReset  = 13'd640;
  localparam logic [DimW-1:0] HeightReset = 13'd480;

  typedef enum logic [2:0] {
    DEPTH_1  = 3'd0,
    DEPTH_4  = 3'd1,
    DEPTH_8  = 3'd2,
    DEPTH_16 = 3'd3,
    DEPTH_24 = 3'd4,
    DEPTH_32 = 3'd5
  } depth_e;

  // Pixels from one data byte, waiting to be sent one per cycle unless stalled.
  typedef struct packed {
    logic [31:0]       word;      // assembled pixel, or the raw byte at 1/4/8 bpp
    depth_e            depth;
    logic [3:0]        count;     // number of pixels, 1 to 8
    logic [DimW-1:0]   col;       // column of the first pixel
    logic [CoordW-1:0] row;       // reported image row
    logic              last_row;  // byte belongs to the last file row
  } burst_t;

  // Undefined depth codes behave as 8 bits per pixel.
  function automatic depth_e to_depth(logic [2:0] code);
    depth_e d;
    unique case (code)
      3'd0:    d = DEPTH_1;
      3'd1:    d = DEPTH_4;
      3'd3:    d = DEPTH_16;
      3'd4:    d = DEPTH_24;
      3'd5:    d = DEPTH_32;
      default: d = DEPTH_8;
    endcase
    return d;
  endfunction

  // Clamp a dimension register into 1..MaxDim.
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = {{(DimW-1){1'b0}}, 1'b1};
    end else if (v > MaxDim) begin
      r = MaxDim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: design/bru_step.sv
// ----------------------------------------------------------------------------
// bru_step
// Row position tracking and per-byte pixel extraction for the unpacker.
// ----------------------------------------------------------------------------
module bru_step (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         take_i,
  input  logic [7:0]                   data_byte_i,
  input  bru_pkg::depth_e              depth_i,
  input  logic [bru_pkg::DimW-1:0]     width_i,
  input  logic [bru_pkg::DimW-1:0]     height_i,
  output logic                         burst_valid_o,
  output bru_pkg::burst_t              burst_o
);

  logic [bru_pkg::RowByteW-1:0] rbc_q, rbc_d;
  logic [bru_pkg::DimW-1:0]     col_q, col_d;
  logic [bru_pkg::DimW-1:0]     frow_q, frow_d;
  logic [23:0]                  part_q, part_d;
  logic [1:0]                   bip_q, bip_d;

  logic [15:0]              w16;
  logic [15:0]              row_bytes;
  logic [15:0]              padded;
  logic [15:0]              rbc_inc;
  logic                     row_end;
  logic                     in_data;
  logic                     col_ok;
  logic [bru_pkg::DimW-1:0] room;
  logic [2:0]               nbytes;
  logic                     gather;
  logic [3:0]               count;
  logic [31:0]              word;
  logic [7:0]               b0, b1, b2;
  logic [bru_pkg::DimW:0]   frow_inc;

  assign w16 = {3'b000, width_i};

  always_comb begin
    unique case (depth_i)
      bru_pkg::DEPTH_1:  row_bytes = (w16 + 16'd7) >> 3;
      bru_pkg::DEPTH_4:  row_bytes = (w16 + 16'd1) >> 1;
      bru_pkg::DEPTH_16: row_bytes = w16 << 1;
      bru_pkg::DEPTH_24: row_bytes = (w16 << 1) + w16;
      bru_pkg::DEPTH_32: row_bytes = w16 << 2;
      default:           row_bytes = w16;
    endcase
  end

  assign padded  = (row_bytes + 16'd3) & ~16'd3;
  assign rbc_inc = {1'b0, rbc_q} + 16'd1;
  assign row_end = (rbc_inc >= padded);
  assign in_data = ({1'b0, rbc_q} < row_bytes);
  assign col_ok  = (col_q < width_i);
  assign room    = width_i - col_q;

  always_comb begin
    unique case (depth_i)
      bru_pkg::DEPTH_24: nbytes = 3'd3;
      bru_pkg::DEPTH_32: nbytes = 3'd4;
      default:           nbytes = 3'd2;
    endcase
  end

  assign gather = (({1'b0, bip_q} + 3'd1) < nbytes);
  assign b0 = part_q[7:0];
  assign b1 = part_q[15:8];
  assign b2 = part_q[23:16];

  // Pixel count and word for this byte, and the wide-pixel gather state.
  always_comb begin
    count  = 4'd0;
    word   = {24'd0, data_byte_i};
    part_d = part_q;
    bip_d  = bip_q;
    unique case (depth_i)
      bru_pkg::DEPTH_1: begin
        if (in_data && col_ok) begin
          count = (room >= 13'd8) ? 4'd8 : room[3:0];
        end
      end
      bru_pkg::DEPTH_4: begin
        if (in_data && col_ok) begin
          count = (room >= 13'd2) ? 4'd2 : room[3:0];
        end
      end
      bru_pkg::DEPTH_16, bru_pkg::DEPTH_24, bru_pkg::DEPTH_32: begin
        unique case (depth_i)
          bru_pkg::DEPTH_16: word = {16'd0, data_byte_i, b0};
          bru_pkg::DEPTH_24: word = {8'd0, data_byte_i, b0, b1};
          default:           word = {b1, b2, data_byte_i, b0};
        endcase
        if (in_data) begin
          if (gather) begin
            unique case (bip_q)
              2'd0:    part_d = part_q | {16'd0, data_byte_i};
              2'd1:    part_d = part_q | {8'd0, data_byte_i, 8'd0};
              2'd2:    part_d = part_q | {data_byte_i, 16'd0};
              default: part_d = part_q;
            endcase
            bip_d = bip_q + 2'd1;
          end else begin
            part_d = '0;
            bip_d  = '0;
            count  = col_ok ? 4'd1 : 4'd0;
          end
        end
      end
      default: begin
        if (in_data && col_ok) begin
          count = 4'd1;
        end
      end
    endcase
  end

  assign frow_inc = {1'b0, frow_q} + 1'b1;

  always_comb begin
    if (row_end) begin
      rbc_d  = '0;
      col_d  = '0;
      frow_d = (frow_inc >= {1'b0, height_i}) ? '0 : frow_inc[bru_pkg::DimW-1:0];
    end else begin
      rbc_d  = rbc_inc[bru_pkg::RowByteW-1:0];
      col_d  = col_q + {{(bru_pkg::DimW-4){1'b0}}, count};
      frow_d = frow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbc_q  <= '0;
      col_q  <= '0;
      frow_q <= '0;
      part_q <= '0;
      bip_q  <= '0;
    end else if (take_i) begin
      rbc_q  <= rbc_d;
      col_q  <= col_d;
      frow_q <= frow_d;
      part_q <= row_end ? '0 : part_d;
      bip_q  <= row_end ? '0 : bip_d;
    end
  end

  logic [bru_pkg::DimW-1:0] img_row;
  assign img_row = (frow_q < height_i) ? (height_i - 13'd1 - frow_q) : '0;

  assign burst_valid_o     = take_i && (count != 4'd0);
  assign burst_o.word      = word;
  assign burst_o.depth     = depth_i;
  assign burst_o.count     = count;
  assign burst_o.col       = col_q;
  assign burst_o.row       = img_row[bru_pkg::CoordW-1:0];
  assign burst_o.last_row  = (frow_q == (height_i - 13'd1));

endmodule

FILE: design/bru_emit.sv
// ----------------------------------------------------------------------------
// bru_emit
// Holds the pixels of one byte and sends them one per cycle through the
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
module bru_emit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           burst_valid_i,
  input  bru_pkg::burst_t                burst_i,
  output logic                           free_o,
  input  logic [bru_pkg::DimW-1:0]       width_m1_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    pixel_value_o,
  output logic [bru_pkg::CoordW-1:0]     column_o,
  output logic [bru_pkg::CoordW-1:0]     row_o,
  output logic                           last_of_run_o,
  output logic                           end_of_row_o,
  output logic                           end_of_image_o
);

  logic            bvalid_q, bvalid_d;
  bru_pkg::burst_t burst_q;
  logic [2:0]      k_q, k_d;

  logic                     out_load;
  logic                     burst_last;
  logic [31:0]              pix;
  logic [bru_pkg::DimW-1:0] col;
  logic                     eor;

  assign out_load   = bvalid_q && (!out_valid_o || out_ready_i);
  assign burst_last = ({1'b0, k_q} == (burst_q.count - 4'd1));
  assign free_o     = !bvalid_q || (out_load && burst_last);

  always_comb begin
    unique case (burst_q.depth)
      bru_pkg::DEPTH_1: pix = {31'd0, burst_q.word[~k_q]};
      bru_pkg::DEPTH_4: pix = (k_q == 3'd0) ? {28'd0, burst_q.word[7:4]}
                                            : {28'd0, burst_q.word[3:0]};
      default:          pix = burst_q.word;
    endcase
  end

  assign col = burst_q.col + {{(bru_pkg::DimW-3){1'b0}}, k_q};
  assign eor = (col == width_m1_i);

  always_comb begin
    bvalid_d = bvalid_q;
    k_d      = k_q;
    if (free_o) begin
      bvalid_d = burst_valid_i;
      k_d      = '0;
    end else if (out_load) begin
      k_d = k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q    <= 1'b0;
      k_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      bvalid_q <= bvalid_d;
      k_q      <= k_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && burst_valid_i) begin
      burst_q <= burst_i;
    end
    if (out_load) begin
      pixel_value_o  <= pix;
      column_o       <= col[bru_pkg::CoordW-1:0];
      row_o          <= burst_q.row;
      last_of_run_o  <= burst_last;
      end_of_row_o   <= eor;
      end_of_image_o <= eor && burst_q.last_row;
    end
  end

  // The pixel index never runs past the pixels the byte produced.
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bvalid_q |-> ({1'b0, k_q} < burst_q.count))
    else $error("pixel index beyond burst count");

  // A held burst with pixels still to send stays held.
  a_burst_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !burst_last) |=> bvalid_q)
    else $error("burst dropped before its last pixel");

  // The last pixel of the image is always the last pixel of a row.
  a_eoi_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_image_o) |-> end_of_row_o)
    else $error("end of image without end of row");

endmodule

FILE: design/bmp_row_pixel_unpacker_core.sv
// ----------------------------------------------------------------------------
// bmp_row_pixel_unpacker_core
// Unpacks the pixel-data bytes of a BMP image into pixels with their
// column and bottom-up row, skipping row padding.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  -------------------------------
//  input     in         in_valid_i / in_ready_o   data_byte_i
//  output    out        out_valid_o / out_ready_i pixel_value_o, column_o, row_o,
//                                                 last_of_run_o, end_of_row_o,
//                                                 end_of_image_o
//  config    in         APB (psel..pready)        depth, width, height registers
//
// A taken byte's pixels wait in the pending pixel set, then go through
// the output register one per cycle while the output is not stalled. A
// byte gives one pixel at 8 bpp and wider, up to two at 4 bpp and up to
// eight at 1 bpp; the next byte is taken as its last pixel is loaded.
// Padding bytes and bytes that only gather part of a wide pixel give no
// pixel and do not hold up the next byte. Reset clears all counters and
// restores the register defaults (8 bpp, 640 x 480). A stalled output
// holds its pixel, and bytes are taken until the pending pixel set is full.
// ----------------------------------------------------------------------------
module bmp_row_pixel_unpacker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Byte input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     data_byte_i,
  // Pixel output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    pixel_value_o,
  output logic [bru_pkg::CoordW-1:0]     column_o,
  output logic [bru_pkg::CoordW-1:0]     row_o,
  output logic                           last_of_run_o,
  output logic                           end_of_row_o,
  output logic                           end_of_image_o,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  // Configuration registers, as written.
  logic [2:0]               depth_q;
  logic [bru_pkg::DimW-1:0] width_q;
  logic [bru_pkg::DimW-1:0] height_q;

  logic       cfg_write;
  logic [1:0] reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= bru_pkg::DepthReset;
      width_q  <= bru_pkg::WidthReset;
      height_q <= bru_pkg::HeightReset;
    end else if (cfg_write) begin
      unique case (reg_idx)
        bru_pkg::RegDepth:  depth_q  <= pwdata[2:0];
        bru_pkg::RegWidth:  width_q  <= pwdata[bru_pkg::DimW-1:0];
        bru_pkg::RegHeight: height_q <= pwdata[bru_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the registers as they were written, before any clamping.
  always_comb begin
    unique case (reg_idx)
      bru_pkg::RegDepth:  prdata = {29'd0, depth_q};
      bru_pkg::RegWidth:  prdata = {19'd0, width_q};
      bru_pkg::RegHeight: prdata = {19'd0, height_q};
      default:            prdata = '0;
    endcase
  end

  // Effective settings: undefined depths act as 8 bpp and the dimensions
  // are clamped to 1..MaxDim.
  bru_pkg::depth_e          depth;
  logic [bru_pkg::DimW-1:0] width;
  logic [bru_pkg::DimW-1:0] height;
  logic [bru_pkg::DimW-1:0] width_m1;

  assign depth    = bru_pkg::to_depth(depth_q);
  assign width    = bru_pkg::clamp_dim(width_q);
  assign height   = bru_pkg::clamp_dim(height_q);
  assign width_m1 = width - 13'd1;

  // A byte transfer happens when the pending pixel set can take new work.
  logic            take;
  logic            burst_valid;
  logic            emit_free;
  bru_pkg::burst_t burst;

  assign in_ready_o = emit_free;
  assign take       = in_valid_i && in_ready_o;

  // Row bookkeeping and extraction of the pixels of each byte.
  bru_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .data_byte_i   (data_byte_i),
    .depth_i       (depth),
    .width_i       (width),
    .height_i      (height),
    .burst_valid_o (burst_valid),
    .burst_o       (burst)
  );

  // Holds one byte's pixels and sends them one per output transfer.
  bru_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .burst_valid_i  (burst_valid),
    .burst_i        (burst),
    .free_o         (emit_free),
    .width_m1_i     (width_m1),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_o  (pixel_value_o),
    .column_o       (column_o),
    .row_o          (row_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BMP row pixel unpacker. A short list of
// directed bytes and register writes walks every pixel depth and the corner
// cases of row padding, clamping and mid-image register changes. A long
// random run follows. Every pixel that leaves the block is compared with a
// bench-side model of the unpacker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CoordW = bru_pkg::CoordW;
  localparam int DimW   = bru_pkg::DimW;

  // One pixel transfer as the output channel carries it.
  typedef struct packed {
    logic [31:0]       pixel_value;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    logic              last_of_run;
    logic              end_of_row;
    logic              end_of_image;
  } pixel_t;

  // One line of the directed stimulus list: either a data byte or a
  // register write. A byte line may carry the single pixel it must produce.
  typedef enum logic {LINE_BYTE, LINE_WRITE} line_kind_e;
  typedef struct packed {
    line_kind_e        kind;
    logic [1:0]        reg_idx;
    logic [DimW-1:0]   value;      // data byte, or the register value
    logic              has_pixel;
    logic [31:0]       pixel;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] img_row;
  } stim_line_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        data_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [31:0]       pixel_value_o;
  logic [CoordW-1:0] column_o;
  logic [CoordW-1:0] row_o;
  logic              last_of_run_o;
  logic              end_of_row_o;
  logic              end_of_image_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Bench copy of the configuration registers and of the unpacker state.
  logic [2:0]      cfg_depth  = bru_pkg::DepthReset;
  logic [DimW-1:0] cfg_width  = bru_pkg::WidthReset;
  logic [DimW-1:0] cfg_height = bru_pkg::HeightReset;
  int unsigned     st_row_bytes = 0;
  int unsigned     st_next_col  = 0;
  int unsigned     st_file_row  = 0;
  logic [31:0]     st_partial   = '0;
  int unsigned     st_byte_idx  = 0;

  // Pixels predicted but not yet seen on the output, oldest first.
  pixel_t      pixel_q[$];
  int unsigned mismatches = 0;

  // Idle and stall rates in percent; both are zero for the closing stretch.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  bmp_row_pixel_unpacker_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_o  (pixel_value_o),
    .column_o       (column_o),
    .row_o          (row_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_image_o (end_of_image_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop. The slowest legal run is well under a tenth of this.
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Bench model of the unpacker
  // ---------------------------------------------------------------------------

  // Dimension registers are clamped into 1..MaxDim before use.
  function automatic int unsigned dim_of(logic [DimW-1:0] v);
    if (v == '0) return 1;
    if (v > bru_pkg::MaxDim) return int'(bru_pkg::MaxDim);
    return int'(v);
  endfunction

  // Undefined depth codes fall back to 8 bits per pixel.
  function automatic int unsigned pixel_bits();
    case (cfg_depth)
      bru_pkg::DEPTH_1:  return 1;
      bru_pkg::DEPTH_4:  return 4;
      bru_pkg::DEPTH_16: return 16;
      bru_pkg::DEPTH_24: return 24;
      bru_pkg::DEPTH_32: return 32;
      default:           return 8;
    endcase
  endfunction

  function automatic int unsigned data_row_bytes();
    return (dim_of(cfg_width) * pixel_bits() + 7) / 8;
  endfunction

  // Builds the pixel at the current column and moves the column on.
  function automatic pixel_t next_pixel(logic [31:0] value, int unsigned w, int unsigned h);
    pixel_t p;
    p.pixel_value  = value;
    p.column       = st_next_col[CoordW-1:0];
    // A file row beyond the image height reports image row zero.
    p.row          = (st_file_row < h) ? CoordW'(h - 1 - st_file_row) : '0;
    p.last_of_run  = 1'b0;
    p.end_of_row   = (st_next_col == w - 1);
    p.end_of_image = p.end_of_row && (st_file_row == h - 1);
    st_next_col++;
    return p;
  endfunction

  // Works out the pixels that one accepted data byte produces, queues them
  // and advances the row, column and wide-pixel state.
  task automatic unpack_byte(input logic [7:0] b, output int n);
    int unsigned w, h, bpp, rowbytes, padded, nbytes;
    logic [7:0]  b0, b1, b2;
    logic [31:0] v;
    pixel_t      run[$];
    pixel_t      p;
    w        = dim_of(cfg_width);
    h        = dim_of(cfg_height);
    bpp      = pixel_bits();
    rowbytes = data_row_bytes();
    padded   = ((rowbytes + 3) / 4) * 4;

    // Bytes past the data part of the row are padding and give nothing.
    if (st_row_bytes < rowbytes) begin
      if (bpp == 1) begin
        for (int k = 0; k < 8 && st_next_col < w; k++) begin
          run.push_back(next_pixel(32'(b[7-k]), w, h));
        end
      end else if (bpp == 4) begin
        if (st_next_col < w) run.push_back(next_pixel(32'(b[7:4]), w, h));
        if (st_next_col < w) run.push_back(next_pixel(32'(b[3:0]), w, h));
      end else if (bpp == 8) begin
        if (st_next_col < w) run.push_back(next_pixel(32'(b), w, h));
      end else begin
        nbytes = bpp / 8;
        if (st_byte_idx + 1 < nbytes) begin
          st_partial  = (st_partial | (32'(b) << (8 * (st_byte_idx & 3)))) & 32'h00FF_FFFF;
          st_byte_idx = (st_byte_idx + 1) & 3;
        end else begin
          b0 = st_partial[7:0];
          b1 = st_partial[15:8];
          b2 = st_partial[23:16];
          // Channel order as the file stores it at each width.
          if (nbytes == 2) v = {16'h0, b, b0};
          else if (nbytes == 3) v = {8'h0, b, b0, b1};
          else v = {b1, b2, b, b0};
          st_partial  = '0;
          st_byte_idx = 0;
          if (st_next_col < w) run.push_back(next_pixel(v, w, h));
        end
      end
    end

    n = run.size();
    if (n > 0) begin
      p = run.pop_back();
      p.last_of_run = 1'b1;
      run.push_back(p);
    end
    foreach (run[i]) pixel_q.push_back(run[i]);

    // Row end also drops any half-gathered wide pixel.
    st_row_bytes++;
    if (st_row_bytes >= padded) begin
      st_row_bytes = 0;
      st_next_col  = 0;
      st_partial   = '0;
      st_byte_idx  = 0;
      st_file_row++;
      if (st_file_row >= h) st_file_row = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one byte, with a random idle burst ahead of it, and waits for the
  // transfer. Valid stays high between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, output int n);
    @(negedge clk_i);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid_i  = 1'b0;
      data_byte_i = 8'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    data_byte_i = b;
    do @(posedge clk_i); while (!in_ready_o);
    unpack_byte(b, n);
  endtask

  // Holds the input back until every predicted pixel has been seen, then keeps
  // waiting so that a byte without pixels is also done.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    wait_idle();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      bru_pkg::RegDepth:  cfg_depth  = value[2:0];
      bru_pkg::RegWidth:  cfg_width  = value[DimW-1:0];
      bru_pkg::RegHeight: cfg_height = value[DimW-1:0];
      default:            ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Output side: stall bursts of random length, at the current stall rate.
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output check
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Each pixel transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        $error("pixel 0x%0h at column %0d, row %0d with none predicted",
               pixel_value_o, column_o, row_o);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        check_field("pixel_value", want.pixel_value, pixel_value_o);
        check_field("column", 32'(want.column), 32'(column_o));
        check_field("row", 32'(want.row), 32'(row_o));
        check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run_o));
        check_field("end_of_row", 32'(want.end_of_row), 32'(end_of_row_o));
        check_field("end_of_image", 32'(want.end_of_image), 32'(end_of_image_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic stim_line_t reg_line(logic [1:0] idx, logic [DimW-1:0] value);
    return '{LINE_WRITE, idx, value, 1'b0, 32'h0, '0, '0};
  endfunction

  function automatic stim_line_t byte_line(logic [7:0] b);
    return '{LINE_BYTE, 2'd0, DimW'(b), 1'b0, 32'h0, '0, '0};
  endfunction

  function automatic stim_line_t pixel_line(logic [7:0] b, logic [31:0] pixel,
                                            logic [CoordW-1:0] col,
                                            logic [CoordW-1:0] img_row);
    return '{LINE_BYTE, 2'd0, DimW'(b), 1'b1, pixel, col, img_row};
  endfunction

  // Dimension values for the extreme phases: zero, one, the maximum, just
  // past it, all ones, or anything the register holds.
  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DimW'(1);
      2:       return bru_pkg::MaxDim;
      3:       return bru_pkg::MaxDim + DimW'(1);
      4:       return '1;
      default: return DimW'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 20;
      default: return 50;
    endcase
  endfunction

  initial begin
    stim_line_t  directed[$];
    pixel_t      p;
    int          n;
    int unsigned items, count, padded, remaining;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;

    // Reset defaults: 8 bpp, 640 x 480, so the first bytes land in the top
    // image row (479) and come back unchanged.
    directed.push_back(pixel_line(8'h00, 32'h00, 12'd0, 12'd479));
    directed.push_back(pixel_line(8'hFF, 32'hFF, 12'd1, 12'd479));
    // Shrink the image in the middle of a row. An undefined depth code acts
    // as 8 bpp; the byte at column 2 closes the 3-pixel row.
    directed.push_back(reg_line(bru_pkg::RegDepth, DimW'(3'd7)));
    directed.push_back(reg_line(bru_pkg::RegWidth, DimW'(3)));
    directed.push_back(reg_line(bru_pkg::RegHeight, DimW'(2)));
    directed.push_back(pixel_line(8'h5A, 32'h5A, 12'd2, 12'd1));
    directed.push_back(byte_line(8'h77));
    // Now one file row in, drop the height to one: the row counter sits past
    // the image, so the row reads zero and no end of image is flagged. A
    // width of zero is clamped to one pixel.
    directed.push_back(reg_line(bru_pkg::RegHeight, DimW'(1)));
    directed.push_back(reg_line(bru_pkg::RegWidth, DimW'(0)));
    directed.push_back(pixel_line(8'h80, 32'h80, 12'd0, 12'd0));
    directed.push_back(byte_line(8'hC3));
    directed.push_back(byte_line(8'h3C));
    directed.push_back(byte_line(8'hFF));
    // 1 bpp, 11 pixels: eight from the first byte, then three, and the tail
    // bits of the second byte fall past the row.
    directed.push_back(reg_line(bru_pkg::RegDepth, DimW'(bru_pkg::DEPTH_1)));
    directed.push_back(reg_line(bru_pkg::RegWidth, DimW'(11)));
    directed.push_back(byte_line(8'hA5));
    directed.push_back(byte_line(8'h3C));
    directed.push_back(byte_line(8'h00));
    directed.push_back(byte_line(8'hFF));
    // 4 bpp, 7 pixels: the low nibble of the last byte gives nothing.
    directed.push_back(reg_line(bru_pkg::RegDepth, DimW'(bru_pkg::DEPTH_4)));
    directed.push_back(reg_line(bru_pkg::RegWidth, DimW'(7)));
    directed.push_back(byte_line(8'h12));
    directed.push_back(byte_line(8'h34));
    directed.push_back(byte_line(8'h56));
    directed.push_back(byte_line(8'h78));
    // 16 bpp, one pixel per row, then 32 bpp from the middle of that row:
    // two gathered bytes are dropped when the row ends.
    directed.push_back(reg_line(bru_pkg::RegDepth, DimW'(bru_pkg::DEPTH_16)));
    directed.push_back(reg_line(bru_pkg::RegWidth, DimW'(1)));
    directed.push_back(byte_line(8'h34));
    directed.push_back(pixel_line(8'h12, 32'h0000_1234, 12'd0, 12'd0));
    directed.push_back(reg_line(bru_pkg::RegDepth, DimW'(bru_pkg::DEPTH_32)));
    directed.push_back(byte_line(8'hEE));
    directed.push_back(byte_line(8'hDD));
    directed.push_back(byte_line(8'h11));
    directed.push_back(byte_line(8'h22));
    directed.push_back(byte_line(8'h33));
    directed.push_back(pixel_line(8'h44, 32'h2233_4411, 12'd0, 12'd0));
    directed.push_back(reg_line(bru_pkg::RegDepth, DimW'(bru_pkg::DEPTH_24)));
    directed.push_back(byte_line(8'h10));
    directed.push_back(byte_line(8'h20));
    directed.push_back(pixel_line(8'h30, 32'h0030_1020, 12'd0, 12'd0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    gap_pct   = 20;
    stall_pct = 20;
    foreach (directed[i]) begin
      if (directed[i].kind == LINE_WRITE) begin
        write_reg(directed[i].reg_idx, 32'(directed[i].value));
      end else begin
        send_byte(directed[i].value[7:0], n);
        if (directed[i].has_pixel) begin
          // The typed-in pixel replaces the modeled one, flags kept.
          if (n != 1) begin
            $error("directed byte %0d gives %0d pixels, one expected", i, n);
            mismatches++;
          end else begin
            p = pixel_q.pop_back();
            p.pixel_value = directed[i].pixel;
            p.column      = directed[i].col;
            p.row         = directed[i].img_row;
            pixel_q.push_back(p);
          end
        end
      end
    end

    // Random phases. Most phases pick a small image and send whole padded
    // rows from wherever the row position stands, so rows and images wrap
    // often. Some stop mid-row, and some jump to extreme dimensions for a
    // few bytes, which leaves the next phase starting mid-image. Each phase
    // begins with the input held until all pixels are out.
    items = 0;
    while (items < 430) begin
      wait_idle();
      if (items >= 370) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end

      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1) == 1) write_reg(bru_pkg::RegDepth, $urandom_range(0, 7));
        if ($urandom_range(0, 2) != 0) write_reg(bru_pkg::RegWidth, 32'(pick_dim()));
        if ($urandom_range(0, 2) != 0) write_reg(bru_pkg::RegHeight, 32'(pick_dim()));
        count = $urandom_range(1, 12);
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(bru_pkg::RegDepth, $urandom_range(0, 7));
        if ($urandom_range(0, 3) != 0) write_reg(bru_pkg::RegWidth, $urandom_range(1, 12));
        if ($urandom_range(0, 3) != 0) write_reg(bru_pkg::RegHeight, $urandom_range(1, 4));
        padded    = ((data_row_bytes() + 3) / 4) * 4;
        remaining = (st_row_bytes >= padded) ? 1 : padded - st_row_bytes;
        if ($urandom_range(0, 3) == 0) begin
          count = $urandom_range(1, 10);
        end else begin
          count = remaining + padded * $urandom_range(0, 2);
          if (count > 64) count = $urandom_range(8, 64);
        end
      end

      repeat (count) begin
        send_byte(8'($urandom_range(0, 255)), n);
        items++;
      end
    end

    // Let the last pixels drain and give the block time to show any extra.
    wait_idle();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: bmp_row_pixel_unpacker_core.f
design/bru_pkg.sv
design/bru_step.sv
design/bru_emit.sv
design/bmp_row_pixel_unpacker_core.sv
tb/tb_top.sv
